// ===== rtl/kdar_pkg.sv =====
// ---------------------------------------------------------------------------
// kdar_pkg: shared types and constants for the key debouncer
// Field widths, register reset values, controller states and the command
// and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package kdar_pkg;

  localparam int unsigned TIME_W     = 32;  // millisecond timestamps
  localparam int unsigned DBNC_W     = 10;  // debounce time register
  localparam int unsigned RPT_W      = 14;  // repeat timing registers
  localparam int unsigned CFG_W      = 14;  // widest register
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KEY_FIELDS = 4;   // keys present on the ports
  localparam int unsigned PROD_W     = 2 * RPT_W;

  // divider: one quotient bit per sub-step, two sub-steps per cycle
  localparam int unsigned DIV_BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS         = RPT_W / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

  localparam logic [DBNC_W-1:0] DEBOUNCE_RST = DBNC_W'(25);
  localparam logic [RPT_W-1:0]  START_RST    = RPT_W'(260);
  localparam logic [RPT_W-1:0]  MIN_RST      = RPT_W'(30);
  localparam logic [RPT_W-1:0]  RAMP_RST     = RPT_W'(700);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TIME = 2'd0,
    REG_START_DELAY   = 2'd1,
    REG_MIN_INTERVAL  = 2'd2,
    REG_RAMP_TIME     = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_INTV,
    S_MUL,
    S_DIV,
    S_FIRE,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;      // capture the polled word
    logic eval;      // debounce update of the current key
    logic intv;      // held time and repeat decision
    logic mul;       // span times held, load divider
    logic div_step;  // divider iteration
    logic fire;      // repeat test, held time into result
    logic publish;   // move finished result to output register
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;  // key is held and still on the ramp
  } dp_sts_t;

endpackage

// ===== rtl/kdar_ctrl.sv =====
// ---------------------------------------------------------------------------
// kdar_ctrl: sequencer for the key debouncer
// Walks the keys one at a time through debounce, interval and repeat steps,
// runs the divider for keys on the ramp, and owns both handshakes.
// ---------------------------------------------------------------------------
module kdar_ctrl import kdar_pkg::*; #(
  parameter int unsigned NK = 4,
  parameter int unsigned KW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dp_cmd_t       cmd_o,
  input  dp_sts_t       sts_i,
  output logic [KW-1:0] key_idx_o
);

  localparam logic [KW-1:0]        KEY_LAST = KW'(NK - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  ctrl_state_e          state_q, state_d;
  logic [KW-1:0]        key_q, key_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    key_d       = key_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          key_d      = '0;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_INTV;
      end
      S_INTV: begin
        cmd_o.intv = 1'b1;
        state_d    = sts_i.need_div ? S_MUL : S_FIRE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_FIRE;
        end else begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
      end
      S_FIRE: begin
        cmd_o.fire = 1'b1;
        if (key_q == KEY_LAST) begin
          state_d = S_DONE;
        end else begin
          key_d   = key_q + 1'b1;
          state_d = S_EVAL;
        end
      end
      S_DONE: begin
        // result register frees up when the old word is taken
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign key_idx_o   = key_q;

  a_accept_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EVAL))
    else $error("accepted word did not start key walk");

  a_div_ends_in_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == DIV_LAST) |=> (state_q == S_FIRE))
    else $error("divider did not hand over to repeat test");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result shown before all keys were walked");

endmodule

// ===== rtl/kdar_dp.sv =====
// ---------------------------------------------------------------------------
// kdar_dp: datapath of the key debouncer
// Per-key debounce state, configuration registers, span multiplier, radix-4
// restoring divider for the repeat interval, result and output registers.
// ---------------------------------------------------------------------------
module kdar_dp import kdar_pkg::*; #(
  parameter int unsigned NK = 4,
  parameter int unsigned KW = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [KEY_FIELDS-1:0] key_levels_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [KW-1:0]         key_idx_i,
  output logic [NK-1:0]         pressed_o,
  output logic [NK-1:0]         repeat_o,
  output logic [NK-1:0]         raw_down_o,
  output logic [TIME_W-1:0]     held_o [NK]
);

  // configuration
  logic [DBNC_W-1:0] dbnc_q;
  logic [RPT_W-1:0]  start_q, minv_q, ramp_q;
  logic [RPT_W-1:0]  minv_eff, span;

  // polled word
  logic [TIME_W-1:0] now_q;
  logic [NK-1:0]     lv_q;

  // per-key state
  logic [NK-1:0]     last_raw_q, deb_q;
  logic [TIME_W-1:0] chg_q [NK];
  logic [TIME_W-1:0] pst_q [NK];
  logic [TIME_W-1:0] lrep_q [NK];

  // per-key working values
  logic              edge_q, chk_q, div_used_q;
  logic [TIME_W-1:0] held_q;
  logic [RPT_W-1:0]  rem_q, dq_q;
  logic [RPT_W-1:0]  rem_d, dq_d;

  // result being built and result on the port
  logic [NK-1:0]     pressed_acc_q, rep_acc_q;
  logic [TIME_W-1:0] held_acc_q [NK];
  logic [NK-1:0]     out_pressed_q, out_rep_q, out_raw_q;
  logic [TIME_W-1:0] out_held_q [NK];

  logic              raw_w, edge_w, chk_w, need_div_w, fire_w;
  logic [TIME_W-1:0] since_chg_w, held_w, since_rep_w;
  logic [RPT_W-1:0]  intv_w;
  logic [PROD_W-1:0] prod_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbnc_q  <= DEBOUNCE_RST;
      start_q <= START_RST;
      minv_q  <= MIN_RST;
      ramp_q  <= RAMP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DEBOUNCE_TIME: dbnc_q  <= cfg_data_i[DBNC_W-1:0];
        REG_START_DELAY:   start_q <= cfg_data_i[RPT_W-1:0];
        REG_MIN_INTERVAL:  minv_q  <= cfg_data_i[RPT_W-1:0];
        REG_RAMP_TIME:     ramp_q  <= cfg_data_i[RPT_W-1:0];
        default: ;
      endcase
    end
  end

  // a minimum above the start delay pins the interval at the start delay
  assign minv_eff = (minv_q > start_q) ? start_q : minv_q;
  assign span     = start_q - minv_eff;

  // debounce step
  assign raw_w       = lv_q[key_idx_i];
  assign since_chg_w = now_q - chg_q[key_idx_i];
  assign edge_w      = (raw_w == last_raw_q[key_idx_i]) &&
                       (since_chg_w >= TIME_W'(dbnc_q)) &&
                       (raw_w != deb_q[key_idx_i]) && !raw_w;

  // interval step
  assign held_w     = now_q - pst_q[key_idx_i];
  assign chk_w      = !deb_q[key_idx_i] && !edge_q;
  assign need_div_w = chk_w && (held_w < TIME_W'(ramp_q));
  assign sts_o.need_div = need_div_w;

  // held < ramp here, so the low bits carry all of it
  assign prod_w = PROD_W'(span) * PROD_W'(held_q[RPT_W-1:0]);

  always_comb begin
    logic [RPT_W-1:0] r;
    logic [RPT_W-1:0] q;
    logic [RPT_W:0]   t;
    r = rem_q;
    q = dq_q;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      t = {r, q[RPT_W-1]};
      q = {q[RPT_W-2:0], 1'b0};
      if (t >= {1'b0, ramp_q}) begin
        r    = RPT_W'(t - {1'b0, ramp_q});
        q[0] = 1'b1;
      end else begin
        r = t[RPT_W-1:0];
      end
    end
    rem_d = r;
    dq_d  = q;
  end

  // repeat test
  assign intv_w      = div_used_q ? (start_q - dq_q) : minv_eff;
  assign since_rep_w = now_q - lrep_q[key_idx_i];
  assign fire_w      = chk_q && (since_rep_w >= TIME_W'(intv_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= '1;
      deb_q      <= '1;
      for (int k = 0; k < NK; k++) begin
        chg_q[k]  <= '0;
        pst_q[k]  <= '0;
        lrep_q[k] <= '0;
      end
    end else begin
      if (cmd_i.eval) begin
        if (raw_w != last_raw_q[key_idx_i]) begin
          last_raw_q[key_idx_i] <= raw_w;
          chg_q[key_idx_i]      <= now_q;
        end else if (since_chg_w >= TIME_W'(dbnc_q) && raw_w != deb_q[key_idx_i]) begin
          deb_q[key_idx_i] <= raw_w;
          if (!raw_w) begin
            pst_q[key_idx_i]  <= now_q;
            lrep_q[key_idx_i] <= now_q;
          end
        end
      end
      if (cmd_i.fire && fire_w) begin
        lrep_q[key_idx_i] <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q         <= now_ms_i;
      lv_q          <= key_levels_i[NK-1:0];
      pressed_acc_q <= '0;
      rep_acc_q     <= '0;
    end
    if (cmd_i.eval) begin
      edge_q <= edge_w;
      if (edge_w) begin
        pressed_acc_q[key_idx_i] <= 1'b1;
        rep_acc_q[key_idx_i]     <= 1'b1;
      end
    end
    if (cmd_i.intv) begin
      held_q     <= held_w;
      chk_q      <= chk_w;
      div_used_q <= need_div_w;
    end
    if (cmd_i.mul) begin
      rem_q <= prod_w[PROD_W-1:RPT_W];
      dq_q  <= prod_w[RPT_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
    if (cmd_i.fire) begin
      held_acc_q[key_idx_i] <= deb_q[key_idx_i] ? '0 : held_q;
      if (fire_w) begin
        rep_acc_q[key_idx_i] <= 1'b1;
      end
    end
    if (cmd_i.publish) begin
      out_pressed_q <= pressed_acc_q;
      out_rep_q     <= rep_acc_q;
      out_raw_q     <= ~last_raw_q;
      out_held_q    <= held_acc_q;
    end
  end

  assign pressed_o  = out_pressed_q;
  assign repeat_o   = out_rep_q;
  assign raw_down_o = out_raw_q;
  assign held_o     = out_held_q;

  a_div_rem_below_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < ramp_q))
    else $error("divider remainder not below ramp time");

endmodule

// ===== rtl/key_debounce_accelerating_repeat.sv =====
// ---------------------------------------------------------------------------
// key_debounce_accelerating_repeat: debouncer with accelerating auto-repeat
// Poll in one word per millisecond: timestamp and active-low key levels.
// Each word returns one result word: press, repeat and raw-down masks and
// the debounced held time of every key.
//
// Input channel (in_valid_i / in_stall_o) takes a word only while the
// sequencer is idle. Output channel (out_valid_o / out_stall_i) is a
// result register, so the next word is taken while a result still waits.
// A word is taken only once the previous one has been walked through all
// keys and published.
// The keys are walked one after another; a key on the ramp passes through
// the span multiplier and then the shared divider, two quotient bits per
// cycle.
// A stalled output holds its word; a finished result then waits inside
// until the register frees up, and no new word is taken meanwhile.
// Reset: keys released, timers zero, registers at defaults 25, 260, 30, 700.
// Registers must be written only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module key_debounce_accelerating_repeat import kdar_pkg::*; #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [KEY_FIELDS-1:0] key_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KEY_FIELDS-1:0] pressed_mask_o,
  output logic [KEY_FIELDS-1:0] repeat_mask_o,
  output logic [KEY_FIELDS-1:0] raw_down_mask_o,
  output logic [TIME_W-1:0]     held_key0_o,
  output logic [TIME_W-1:0]     held_key1_o,
  output logic [TIME_W-1:0]     held_key2_o,
  output logic [TIME_W-1:0]     held_key3_o
);

  // keys past the port width always read released and never act
  localparam int unsigned NK = (NUM_KEYS < KEY_FIELDS) ? NUM_KEYS : KEY_FIELDS;
  localparam int unsigned KW = (NK > 1) ? $clog2(NK) : 1;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [KW-1:0]     key_idx;
  logic [NK-1:0]     pressed, rep, raw_down;
  logic [TIME_W-1:0] held [NK];
  logic [TIME_W-1:0] held_port [KEY_FIELDS];

  kdar_ctrl #(
    .NK (NK),
    .KW (KW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .key_idx_o   (key_idx)
  );

  kdar_dp #(
    .NK (NK),
    .KW (KW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .now_ms_i     (now_ms_i),
    .key_levels_i (key_levels_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .key_idx_i    (key_idx),
    .pressed_o    (pressed),
    .repeat_o     (rep),
    .raw_down_o   (raw_down),
    .held_o       (held)
  );

  assign pressed_mask_o  = KEY_FIELDS'(pressed);
  assign repeat_mask_o   = KEY_FIELDS'(rep);
  assign raw_down_mask_o = KEY_FIELDS'(raw_down);

  for (genvar g = 0; g < KEY_FIELDS; g++) begin : g_held
    if (g < NK) begin : g_key
      assign held_port[g] = held[g];
    end else begin : g_none
      assign held_port[g] = '0;
    end
  end

  assign held_key0_o = held_port[0];
  assign held_key1_o = held_port[1];
  assign held_key2_o = held_port[2];
  assign held_key3_o = held_port[3];

endmodule
